// File: hdl/pcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_pkg: shared types and constants of the pwm capture meter
// payload structs, request codes and queue status
// ----------------------------------------------------------------------------
package pcm_pkg;

	localparam int unsigned CAPTURE_W = 16;
	localparam int unsigned DUTY_W    = 7;
	localparam int unsigned FREQ_W    = 24;
	localparam int unsigned TICK_W    = 24;

	localparam logic [TICK_W-1:0] TICK_HZ_RESET = 24'd1000000;
	localparam logic [DUTY_W-1:0] DUTY_SCALE    = 7'd100;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_EDGE  = 1'b1;

	typedef struct packed {
		logic                 req_type;
		logic [CAPTURE_W-1:0] capture_time;
		logic                 rising_edge;
	} cap_item_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_percent;
		logic [FREQ_W-1:0] freq_hz;
		logic              period_zero;
	} meas_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage
`default_nettype wire

// File: hdl/pwm_capture_duty_frequency_meter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_capture_duty_frequency_meter_top: pwm duty and frequency meter
// measures high and low time from capture events, reports duty and frequency
// ----------------------------------------------------------------------------
// usage
//   cap channel: a start item arms the meter, then edge items carry the timer
//   stamp and polarity; first rise, next fall and second rise are used, wrong
//   polarity and edges while idle are dropped
//   meas channel: one item per completed measurement (after the second rise)
//   cfg port: cfg_wr_en / cfg_wr_data set tick_hz, write only while idle
// timing
//   every cap item is taken in the cycle it is offered while the job queue has room
//   after the second rise a job passes the queue, the divider and the output
//   register; the serial divider retires one bit per cycle over
//   max(TIMER_BITS+7, 24) steps, so it sets the sustained rate
// reset
//   arst_n clears the phase, the queue and the output valid; tick_hz returns
//   to 1000000
// stall
//   a stalled result holds in the output register; the divider then waits,
//   the two-entry queue fills and cap_stall rises
// ----------------------------------------------------------------------------
module pwm_capture_duty_frequency_meter_top #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cap_valid,
	output logic                         cap_stall,
	input  pcm_pkg::cap_item_t           cap,
	output logic                         meas_valid,
	input  wire                          meas_stall,
	output pcm_pkg::meas_item_t          meas,
	input  wire                          cfg_wr_en,
	input  wire  [pcm_pkg::TICK_W-1:0]   cfg_wr_data
);
	import pcm_pkg::*;

	localparam int unsigned TW = TIMER_BITS;
	localparam int unsigned JW = 2 * TW + 1;

	logic [TICK_W-1:0] tick_hz_q;
	queue_stat_t       qstat;
	logic              push;
	logic              pop;
	logic [TW-1:0]     f_ton;
	logic [TW:0]       f_period;
	logic [JW-1:0]     q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_hz_q <= TICK_HZ_RESET;
		end else if (cfg_wr_en) begin
			tick_hz_q <= cfg_wr_data;
		end
	end

	pcm_front #(.TW(TW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cap_valid  (cap_valid),
		.cap_stall  (cap_stall),
		.cap        (cap),
		.qstat      (qstat),
		.push       (push),
		.job_ton    (f_ton),
		.job_period (f_period)
	);

	pcm_queue #(.W(JW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_ton, f_period}),
		.pop    (pop),
		.rdata  (q_rdata),
		.qstat  (qstat)
	);

	pcm_back #(.TW(TW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.pop        (pop),
		.job_ton    (q_rdata[JW-1:TW+1]),
		.job_period (q_rdata[TW:0]),
		.tick_hz    (tick_hz_q),
		.meas_valid (meas_valid),
		.meas_stall (meas_stall),
		.meas       (meas)
	);

endmodule
`default_nettype wire

// File: hdl/pcm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_front: capture event front end
// tracks the arm / rise / fall / rise sequence and queues ton and period
// ----------------------------------------------------------------------------
module pcm_front #(
	parameter int unsigned TW = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cap_valid,
	output logic                    cap_stall,
	input  pcm_pkg::cap_item_t      cap,
	input  pcm_pkg::queue_stat_t    qstat,
	output logic                    push,
	output logic [TW-1:0]           job_ton,
	output logic [TW:0]             job_period
);
	import pcm_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_RISE1 = 4'b0010,
		PH_FALL  = 4'b0100,
		PH_RISE2 = 4'b1000
	} phase_t;

	phase_t        phase_q;
	logic [TW-1:0] first_q;
	logic [TW-1:0] fall_q;
	logic [TW-1:0] t_w;
	logic [TW-1:0] toff;
	logic          acc;

	assign cap_stall  = qstat.full;
	assign acc        = cap_valid && !qstat.full;
	assign t_w        = TW'(cap.capture_time);
	assign job_ton    = fall_q - first_q;
	assign toff       = t_w - fall_q;
	assign job_period = {1'b0, job_ton} + {1'b0, toff};
	assign push       = acc && (cap.req_type == REQ_EDGE) && (phase_q == PH_RISE2)
		&& cap.rising_edge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			first_q <= '0;
			fall_q  <= '0;
		end else if (acc) begin
			if (cap.req_type == REQ_START) begin
				phase_q <= PH_RISE1;
			end else begin
				case (phase_q)
					PH_RISE1: begin
						if (cap.rising_edge) begin
							first_q <= t_w;
							phase_q <= PH_FALL;
						end
					end
					PH_FALL: begin
						if (!cap.rising_edge) begin
							fall_q  <= t_w;
							phase_q <= PH_RISE2;
						end
					end
					PH_RISE2: begin
						if (cap.rising_edge) begin
							phase_q <= PH_IDLE;
						end
					end
					default: begin
						phase_q <= PH_IDLE;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/pcm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_queue: two-entry job queue
// decouples the capture front end from the divider
// ----------------------------------------------------------------------------
module pcm_queue #(
	parameter int unsigned W = 33
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire  [W-1:0]         wdata,
	input  wire                  pop,
	output logic [W-1:0]         rdata,
	output pcm_pkg::queue_stat_t qstat
);
	import pcm_pkg::*;

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign rdata       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/pcm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_back: serial divider back end
// two restoring lanes share one count: ton*100/period and tick_hz/period
// ----------------------------------------------------------------------------
module pcm_back #(
	parameter int unsigned TW = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  pcm_pkg::queue_stat_t         qstat,
	output logic                         pop,
	input  wire  [TW-1:0]                job_ton,
	input  wire  [TW:0]                  job_period,
	input  wire  [pcm_pkg::TICK_W-1:0]   tick_hz,
	output logic                         meas_valid,
	input  wire                          meas_stall,
	output pcm_pkg::meas_item_t          meas
);
	import pcm_pkg::*;

	localparam int unsigned PW = TW + 1;
	localparam int unsigned DW = (TW + DUTY_W > TICK_W) ? TW + DUTY_W : TICK_W;
	localparam int unsigned CW = $clog2(DW + 1);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_RUN  = 2'b10
	} back_state_t;

	back_state_t   state_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] qa_q;
	logic [DW-1:0] qb_q;
	logic [PW-1:0] rem_a_q;
	logic [PW-1:0] rem_b_q;
	logic [PW-1:0] div_q;
	logic          zero_q;
	logic          out_valid_q;
	meas_item_t    out_q;

	logic [PW:0]   sh_a;
	logic [PW:0]   sh_b;
	logic          ge_a;
	logic          ge_b;
	logic [PW:0]   dif_a;
	logic [PW:0]   dif_b;
	logic          finish;
	logic          out_free;

	assign pop        = (state_q == B_IDLE) && !qstat.empty;
	assign out_free   = !out_valid_q || !meas_stall;
	assign finish     = (state_q == B_RUN) && (cnt_q == '0) && out_free;
	assign meas_valid = out_valid_q;
	assign meas       = out_q;

	assign sh_a  = {rem_a_q, qa_q[DW-1]};
	assign sh_b  = {rem_b_q, qb_q[DW-1]};
	assign dif_a = sh_a - {1'b0, div_q};
	assign dif_b = sh_b - {1'b0, div_q};
	assign ge_a  = (sh_a >= {1'b0, div_q});
	assign ge_b  = (sh_b >= {1'b0, div_q});

	always_ff @(posedge clk) begin
		if (pop) begin
			qa_q    <= DW'(job_ton) * DW'(DUTY_SCALE);
			qb_q    <= DW'(tick_hz);
			rem_a_q <= '0;
			rem_b_q <= '0;
			div_q   <= job_period;
			zero_q  <= (job_period == '0);
		end else if ((state_q == B_RUN) && (cnt_q != '0)) begin
			qa_q    <= {qa_q[DW-2:0], ge_a};
			qb_q    <= {qb_q[DW-2:0], ge_b};
			rem_a_q <= ge_a ? dif_a[PW-1:0] : sh_a[PW-1:0];
			rem_b_q <= ge_b ? dif_b[PW-1:0] : sh_b[PW-1:0];
		end
		if (finish) begin
			out_q.duty_percent <= zero_q ? '0 : qa_q[DUTY_W-1:0];
			out_q.freq_hz      <= zero_q ? '0 : qb_q[FREQ_W-1:0];
			out_q.period_zero  <= zero_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= B_RUN;
						cnt_q   <= CW'(DW);
					end
				end
				B_RUN: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
					end else if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!meas_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/pcm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_checker: port level checks of the pwm capture meter
// duty range, zero period handling, reset and output hold
// ----------------------------------------------------------------------------
module pcm_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  meas_valid,
	input wire                  meas_stall,
	input pcm_pkg::meas_item_t  meas
);
	import pcm_pkg::*;

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !meas_valid)
		else $error("result valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas_stall |=> meas_valid && $stable(meas))
		else $error("stalled result changed");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas.period_zero |-> (meas.duty_percent == '0) && (meas.freq_hz == '0))
		else $error("zero period with nonzero result");

	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid |-> (meas.duty_percent <= DUTY_SCALE))
		else $error("duty above 100 percent");

endmodule

bind pwm_capture_duty_frequency_meter_top pcm_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.meas_valid (meas_valid),
	.meas_stall (meas_stall),
	.meas       (meas)
);
`default_nettype wire

// File: bench/meas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meas_checker: result predictor and checker for the pwm capture meter
// watches the cap, meas and cfg ports, keeps its own copy of the arming phase,
// the edge stamps and tick_hz, and compares every result field by field
// ----------------------------------------------------------------------------
module meas_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cap_valid,
	input  wire                          cap_stall,
	input  pcm_pkg::cap_item_t           cap,
	input  wire                          meas_valid,
	input  wire                          meas_stall,
	input  pcm_pkg::meas_item_t          meas,
	input  wire                          cfg_wr_en,
	input  wire  [pcm_pkg::TICK_W-1:0]   cfg_wr_data,
	output int                           fails,
	output int                           pending
);
	import pcm_pkg::*;

	typedef enum logic [1:0] {
		ARM_IDLE,
		ARM_FIRST_RISE,
		ARM_FALL,
		ARM_SECOND_RISE
	} arm_t;

	arm_t                 arm_phase;
	logic [CAPTURE_W-1:0] rise_stamp;
	logic [CAPTURE_W-1:0] fall_stamp;
	logic [TICK_W-1:0]    tick_hz;
	meas_item_t           meas_expected[$];
	int                   err_cnt = 0;

	task automatic track_capture(input cap_item_t c);
		logic [CAPTURE_W-1:0] ton;
		logic [CAPTURE_W-1:0] toff;
		longint unsigned      period;
		meas_item_t           m;
		if (c.req_type == REQ_START) begin
			arm_phase = ARM_FIRST_RISE;
			return;
		end
		case (arm_phase)
		ARM_FIRST_RISE: if (c.rising_edge) begin
			rise_stamp = c.capture_time;
			arm_phase = ARM_FALL;
		end
		ARM_FALL: if (!c.rising_edge) begin
			fall_stamp = c.capture_time;
			arm_phase = ARM_SECOND_RISE;
		end
		ARM_SECOND_RISE: if (c.rising_edge) begin
			// high and low time wrap at the timer width, the period does not
			ton = fall_stamp - rise_stamp;
			toff = c.capture_time - fall_stamp;
			period = longint'(ton) + longint'(toff);
			arm_phase = ARM_IDLE;
			m = '0;
			if (period == 0) begin
				m.period_zero = 1'b1;
			end else begin
				m.duty_percent = DUTY_W'((longint'(ton) * longint'(DUTY_SCALE)) / period);
				m.freq_hz = FREQ_W'(longint'(tick_hz) / period);
			end
			meas_expected.push_back(m);
		end
		default: ;
		endcase
	endtask

	task automatic check_meas(input meas_item_t got);
		meas_item_t want;
		if (meas_expected.size() == 0) begin
			$error("meas item with none expected: duty_percent %0d freq_hz %0d period_zero %0d",
				got.duty_percent, got.freq_hz, got.period_zero);
			err_cnt++;
			return;
		end
		want = meas_expected.pop_front();
		if (got.duty_percent !== want.duty_percent) begin
			$error("duty_percent: expected %0d, actual %0d", want.duty_percent, got.duty_percent);
			err_cnt++;
		end
		if (got.freq_hz !== want.freq_hz) begin
			$error("freq_hz: expected %0d, actual %0d", want.freq_hz, got.freq_hz);
			err_cnt++;
		end
		if (got.period_zero !== want.period_zero) begin
			$error("period_zero: expected %0d, actual %0d", want.period_zero, got.period_zero);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_phase = ARM_IDLE;
			rise_stamp = '0;
			fall_stamp = '0;
			tick_hz = TICK_HZ_RESET;
			meas_expected.delete();
			pending <= 0;
			fails <= err_cnt;
		end else begin
			if (cfg_wr_en)
				tick_hz = cfg_wr_data;
			if (cap_valid && !cap_stall)
				track_capture(cap);
			if (meas_valid && !meas_stall)
				check_meas(meas);
			pending <= meas_expected.size();
			fails <= err_cnt;
		end
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the pwm capture duty and frequency meter
// drives start and edge items with random gaps and a random result stall,
// runs a directed set then random measurements under several tick_hz values;
// the checker beside the block predicts and compares the results
// ----------------------------------------------------------------------------
module tb_top;
	import pcm_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 5;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 64;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 200;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cap_valid;
	logic              cap_stall;
	cap_item_t         cap;
	logic              meas_valid;
	logic              meas_stall;
	meas_item_t        meas;
	logic              cfg_wr_en;
	logic [TICK_W-1:0] cfg_wr_data;
	int                fails;
	int                pending;
	int                idle_cycles = 0;
	bit                hold_now = 1'b0;
	bit                tx_burst = 1'b0;

	always #(CLK_HALF) clk = ~clk;

	pwm_capture_duty_frequency_meter_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cap_valid   (cap_valid),
		.cap_stall   (cap_stall),
		.cap         (cap),
		.meas_valid  (meas_valid),
		.meas_stall  (meas_stall),
		.meas        (meas),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	meas_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cap_valid   (cap_valid),
		.cap_stall   (cap_stall),
		.cap         (cap),
		.meas_valid  (meas_valid),
		.meas_stall  (meas_stall),
		.meas        (meas),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fails       (fails),
		.pending     (pending)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(15, 70);
	endfunction

	function automatic cap_item_t cap_of(input logic req, input logic [CAPTURE_W-1:0] t,
			input logic rise);
		cap_item_t c;
		c.req_type = req;
		c.capture_time = t;
		c.rising_edge = rise;
		return c;
	endfunction

	// valid stays high on return so back-to-back items need no second assignment
	task automatic send_cap(input cap_item_t item);
		int gap;
		gap = tx_burst ? 0 : pick_gap();
		if (gap > 0) begin
			cap_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cap_valid <= 1'b1;
		cap <= item;
		do begin
			@(posedge clk);
		end while (cap_stall);
	endtask

	task automatic drain();
		cap_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_tick(input logic [TICK_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_directed();
		// edges while idle
		send_cap(cap_of(REQ_EDGE, 16'hFFFF, 1'b1));
		send_cap(cap_of(REQ_EDGE, 16'h0000, 1'b0));
		// wrong polarity at every phase
		send_cap(cap_of(REQ_START, 16'h0000, 1'b0));
		send_cap(cap_of(REQ_EDGE, 16'h0040, 1'b0));
		send_cap(cap_of(REQ_EDGE, 16'd100, 1'b1));
		send_cap(cap_of(REQ_EDGE, 16'd200, 1'b1));
		send_cap(cap_of(REQ_EDGE, 16'd350, 1'b0));
		send_cap(cap_of(REQ_EDGE, 16'd400, 1'b0));
		send_cap(cap_of(REQ_EDGE, 16'd1100, 1'b1));
		// zero period
		send_cap(cap_of(REQ_START, 16'hFFFF, 1'b1));
		send_cap(cap_of(REQ_EDGE, 16'd5, 1'b1));
		send_cap(cap_of(REQ_EDGE, 16'd5, 1'b0));
		send_cap(cap_of(REQ_EDGE, 16'd5, 1'b1));
		// widest period, the low time wraps
		send_cap(cap_of(REQ_START, 16'h5555, 1'b0));
		send_cap(cap_of(REQ_EDGE, 16'h0000, 1'b1));
		send_cap(cap_of(REQ_EDGE, 16'hFFFF, 1'b0));
		send_cap(cap_of(REQ_EDGE, 16'hFFFE, 1'b1));
		// restart mid measurement, then zero low time
		send_cap(cap_of(REQ_START, 16'hAAAA, 1'b1));
		send_cap(cap_of(REQ_EDGE, 16'd10, 1'b1));
		send_cap(cap_of(REQ_START, 16'd0, 1'b0));
		send_cap(cap_of(REQ_EDGE, 16'd20, 1'b1));
		send_cap(cap_of(REQ_EDGE, 16'd30, 1'b0));
		send_cap(cap_of(REQ_EDGE, 16'd30, 1'b1));
	endtask

	task automatic run_random(input int n_items, input int hold_at);
		int                   sent;
		int                   mode;
		logic [CAPTURE_W-1:0] t;
		logic [CAPTURE_W-1:0] d_on;
		logic [CAPTURE_W-1:0] d_off;
		sent = 0;
		while (sent < n_items) begin
			tx_burst = ($urandom_range(0, 6) == 0);
			if (hold_at >= 0 && sent >= hold_at) begin
				hold_now = 1'b1;
				hold_at = -1;
			end
			if ($urandom_range(0, 99) < 12) begin
				send_cap(cap_of(1'($urandom_range(0, 1)), CAPTURE_W'($urandom),
					1'($urandom_range(0, 1))));
				continue;
			end
			mode = $urandom_range(0, 19);
			if (mode == 0) begin
				d_on = '0;
				d_off = '0;
			end else if (mode < 7) begin
				d_on = CAPTURE_W'($urandom_range(0, 40));
				d_off = CAPTURE_W'($urandom_range(0, 40));
			end else if (mode < 14) begin
				d_on = CAPTURE_W'($urandom_range(0, 3000));
				d_off = CAPTURE_W'($urandom_range(0, 3000));
			end else begin
				d_on = CAPTURE_W'($urandom);
				d_off = CAPTURE_W'($urandom);
			end
			t = CAPTURE_W'($urandom);
			send_cap(cap_of(REQ_START, CAPTURE_W'($urandom), 1'($urandom_range(0, 1))));
			sent++;
			// rise, fall, rise; occasionally cut short or preceded by a wrong edge
			for (int stage = 0; stage < 3; stage++) begin
				if ($urandom_range(0, 24) == 0)
					break;
				if ($urandom_range(0, 11) == 0)
					send_cap(cap_of(REQ_EDGE, CAPTURE_W'($urandom), stage == 1));
				send_cap(cap_of(REQ_EDGE, t, stage != 1));
				sent++;
				t = t + ((stage == 0) ? d_on : d_off);
			end
		end
	endtask

	initial begin
		int run_len;
		int stall_len;
		meas_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_now) begin
				hold_now = 1'b0;
				meas_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
					: $urandom_range(1, 8);
				meas_stall <= 1'b0;
				repeat (run_len) @(posedge clk);
				stall_len = pick_gap();
				if (stall_len > 0) begin
					meas_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cap_valid && !cap_stall) || (meas_valid && !meas_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [TICK_W-1:0] tick_plan[$];
		arst_n = 1'b0;
		cap_valid = 1'b0;
		cap = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		drain();
		tick_plan = '{24'd16000000, 24'd1, 24'd0, 24'h7FFFFF};
		repeat (3) tick_plan.push_back(TICK_W'($urandom_range(1, 16000000)));
		foreach (tick_plan[i]) begin
			set_tick(tick_plan[i]);
			run_random(PHASE_ITEMS, (i == 0) ? 30 : -1);
			drain();
		end
		if (fails == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: pwm_capture_duty_frequency_meter_top.f
hdl/pcm_pkg.sv
hdl/pcm_front.sv
hdl/pcm_queue.sv
hdl/pcm_back.sv
hdl/pwm_capture_duty_frequency_meter_top.sv
hdl/pcm_checker.sv
bench/meas_checker.sv
bench/tb_top.sv
